// ----- design/websocket_frame_deframer_core_assert.svh -----
// Assertion macros used by the deframer parser.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define WSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- design/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_DROP  = 2'd2
  } kind_t;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;
  localparam logic [2:0] KEY_CNT   = 3'd3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       frame_last;
    logic       was_masked;
  } res_t;

endpackage

// ----- design/wsd_in_reg.sv -----
// Input register: holds one received byte until the parser takes it.
module wsd_in_reg
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       adv,
  output logic       byte_vld,
  output logic [7:0] byte_q
);

  assign in_ready = !byte_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_vld <= 1'b1;
    end else if (adv) begin
      byte_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule

// ----- design/wsd_parser.sv -----
// Frame header parser and payload unmasker, one byte per advance.
`include "websocket_frame_deframer_core_assert.svh"
module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [7:0] byte_q,
  output logic       res_vld,
  output res_t       res
);

  phase_t      phase, phase_next;
  logic [3:0]  cur_opcode, cur_opcode_next;
  logic        cur_final, cur_final_next;
  logic        cur_masked, cur_masked_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic [63:0] pay_rem, pay_rem_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_idx, mask_idx_next;
  logic        after_len;
  logic        begin_pay;
  logic        pay_last;
  logic [7:0]  key_byte;

  assign pay_last = (pay_rem == 64'd1);
  // key byte 0 sits in the high bits
  assign key_byte = 8'(mask_key >> (5'd24 - {mask_idx, 3'b000}));

  always_comb begin
    phase_next      = phase;
    cur_opcode_next = cur_opcode;
    cur_final_next  = cur_final;
    cur_masked_next = cur_masked;
    hdr_cnt_next    = hdr_cnt;
    pay_rem_next    = pay_rem;
    mask_key_next   = mask_key;
    mask_idx_next   = mask_idx;
    after_len       = 1'b0;
    begin_pay       = 1'b0;
    res_vld         = 1'b0;
    res.kind        = KIND_DATA;
    res.data_byte   = 8'd0;
    res.frame_last  = 1'b0;

    case (phase)
      PH_LEN: begin
        cur_masked_next = byte_q[7];
        mask_key_next   = 32'd0;
        pay_rem_next    = 64'd0;
        if (byte_q[6:0] == LEN_EXT16) begin
          phase_next   = PH_EXT;
          hdr_cnt_next = EXT16_CNT;
        end else if (byte_q[6:0] == LEN_EXT64) begin
          phase_next   = PH_EXT;
          hdr_cnt_next = EXT64_CNT;
        end else begin
          pay_rem_next = {57'd0, byte_q[6:0]};
          after_len    = 1'b1;
        end
      end
      PH_EXT: begin
        pay_rem_next = {pay_rem[55:0], byte_q};
        if (hdr_cnt != 3'd0) begin
          hdr_cnt_next = hdr_cnt - 3'd1;
        end else begin
          after_len = 1'b1;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], byte_q};
        if (hdr_cnt != 3'd0) begin
          hdr_cnt_next = hdr_cnt - 3'd1;
        end else begin
          begin_pay = 1'b1;
        end
      end
      PH_PAY: begin
        pay_rem_next  = pay_rem - 64'd1;
        mask_idx_next = mask_idx + 2'd1;
        if (pay_last) begin
          phase_next = PH_HDR;
        end
        if (cur_final) begin
          res_vld        = 1'b1;
          res.kind       = KIND_DATA;
          res.data_byte  = byte_q ^ key_byte;
          res.frame_last = pay_last;
        end else if (pay_last) begin
          res_vld        = 1'b1;
          res.kind       = KIND_DROP;
          res.frame_last = 1'b1;
        end
      end
      default: begin
        cur_final_next  = byte_q[7];
        cur_opcode_next = byte_q[3:0];
        cur_masked_next = 1'b0;
        hdr_cnt_next    = 3'd0;
        phase_next      = PH_LEN;
      end
    endcase

    // length done: fetch the key or start the payload
    if (after_len) begin
      if (cur_masked_next) begin
        phase_next   = PH_MASK;
        hdr_cnt_next = KEY_CNT;
      end else begin
        begin_pay = 1'b1;
      end
    end

    // header done: close a zero-length frame at once
    if (begin_pay) begin
      mask_idx_next = 2'd0;
      if (pay_rem_next == 64'd0) begin
        phase_next     = PH_HDR;
        res_vld        = 1'b1;
        res.kind       = cur_final ? KIND_EMPTY : KIND_DROP;
        res.frame_last = 1'b1;
      end else begin
        phase_next = PH_PAY;
      end
    end

    res.frame_opcode = cur_opcode_next;
    res.was_masked   = cur_masked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR;
      cur_opcode <= 4'd0;
      cur_final  <= 1'b0;
      cur_masked <= 1'b0;
      hdr_cnt    <= 3'd0;
      pay_rem    <= 64'd0;
      mask_key   <= 32'd0;
      mask_idx   <= 2'd0;
    end else if (adv) begin
      phase      <= phase_next;
      cur_opcode <= cur_opcode_next;
      cur_final  <= cur_final_next;
      cur_masked <= cur_masked_next;
      hdr_cnt    <= hdr_cnt_next;
      pay_rem    <= pay_rem_next;
      mask_key   <= mask_key_next;
      mask_idx   <= mask_idx_next;
    end
  end

  `WSD_ASSERT_NOW(a_drop_nonfinal, adv && res_vld && res.kind == KIND_DROP, !cur_final)
  `WSD_ASSERT_NOW(a_close_empty, adv && res_vld && res.kind != KIND_DATA,
                  res.frame_last && res.data_byte == 8'd0)
  `WSD_ASSERT_NEXT(a_pay_exit, adv && phase == PH_PAY && pay_last, phase == PH_HDR)
  `WSD_ASSERT_NEXT(a_hdr_to_len, adv && phase == PH_HDR, phase == PH_LEN)

endmodule

// ----- design/wsd_out_reg.sv -----
// Result register: holds one result until the consumer takes it.
module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_t       res,
  output logic       up_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [3:0] frame_opcode,
  output logic       frame_last,
  output logic       was_masked
);

  res_t held;

  assign up_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign kind         = held.kind;
  assign data_byte    = held.data_byte;
  assign frame_opcode = held.frame_opcode;
  assign frame_last   = held.frame_last;
  assign was_masked   = held.was_masked;

endmodule

// ----- design/websocket_frame_deframer_core.sv -----
// A byte is held in the input register, parsed combinationally, then registered in the result register.
// Throughput: one byte per cycle; the parser advances whenever the result register is free.
// The result register frees as its transaction completes, so no bubbles under steady flow.
// Bytes with no result (most header and non-final payload bytes) still wait for a free result register.
// Reset (rst, synchronous, active high): parser returns to first-header-byte, both regs empty.
module websocket_frame_deframer_core
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [3:0] frame_opcode,
  output logic       frame_last,
  output logic       was_masked
);

  logic       byte_vld;
  logic [7:0] byte_q;
  logic       up_ready;
  logic       adv;
  logic       res_vld;
  res_t       res;

  // Advance the parser by one byte when a byte is held and the result slot can take
  // whatever that byte produces.
  assign adv = byte_vld && up_ready;

  // Input stage: capture one byte per input transaction.
  wsd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .adv      (adv),
    .byte_vld (byte_vld),
    .byte_q   (byte_q)
  );

  // Parse header fields, count down the payload, and unmask payload bytes.
  wsd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .byte_q  (byte_q),
    .res_vld (res_vld),
    .res     (res)
  );

  // Output stage: load only steps that produce a result; drop the rest silently.
  wsd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (adv && res_vld),
    .res          (res),
    .up_ready     (up_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .frame_opcode (frame_opcode),
    .frame_last   (frame_last),
    .was_masked   (was_masked)
  );

endmodule

// ----- tb/websocket_frame_deframer_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the WebSocket deframer: predicts results from accepted bytes and checks them.
module websocket_frame_deframer_checker
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  input  logic [3:0] frame_opcode,
  input  logic       frame_last,
  input  logic       was_masked,
  output int         mismatch_count,
  output int         pending_count,
  output int         checked_count
);

  // Parser state of the prediction.
  phase_t      parse_ph     = PH_HDR;
  logic        frame_fin    = 1'b0;
  logic [3:0]  frame_op     = 4'd0;
  logic        frame_masked = 1'b0;
  logic [2:0]  hdr_left     = 3'd0;
  logic [63:0] bytes_left   = 64'd0;
  logic [31:0] mask_word    = 32'd0;
  logic [1:0]  mask_pos     = 2'd0;

  res_t expected_results[$];
  int   mismatches = 0;
  int   checked    = 0;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    checked_count  = 0;
  end

  task automatic queue_result(input kind_t k, input logic [7:0] d, input logic l);
    res_t r;
    r.kind         = k;
    r.data_byte    = d;
    r.frame_opcode = frame_op;
    r.frame_last   = l;
    r.was_masked   = frame_masked;
    expected_results.push_back(r);
  endtask

  // Header done: enter the payload, or close a zero-length frame at once.
  task automatic open_payload();
    mask_pos = 2'd0;
    if (bytes_left == 64'd0) begin
      parse_ph = PH_HDR;
      queue_result(frame_fin ? KIND_EMPTY : KIND_DROP, 8'h00, 1'b1);
    end else begin
      parse_ph = PH_PAY;
    end
  endtask

  task automatic close_length();
    if (frame_masked) begin
      parse_ph = PH_MASK;
      hdr_left = KEY_CNT;
    end else begin
      open_payload();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [7:0] key_byte;
    logic       last;
    case (parse_ph)
      PH_LEN: begin
        frame_masked = b[7];
        mask_word    = 32'd0;
        bytes_left   = 64'd0;
        if (b[6:0] == LEN_EXT16) begin
          parse_ph = PH_EXT;
          hdr_left = EXT16_CNT;
        end else if (b[6:0] == LEN_EXT64) begin
          parse_ph = PH_EXT;
          hdr_left = EXT64_CNT;
        end else begin
          bytes_left = {57'd0, b[6:0]};
          close_length();
        end
      end
      PH_EXT: begin
        bytes_left = {bytes_left[55:0], b};
        if (hdr_left != 3'd0) hdr_left = hdr_left - 3'd1;
        else close_length();
      end
      PH_MASK: begin
        mask_word = {mask_word[23:0], b};
        if (hdr_left != 3'd0) begin
          hdr_left = hdr_left - 3'd1;
        end else begin
          hdr_left = 3'd0;
          open_payload();
        end
      end
      PH_PAY: begin
        key_byte   = mask_word[8 * (3 - mask_pos) +: 8];
        last       = (bytes_left == 64'd1);
        bytes_left = bytes_left - 64'd1;
        mask_pos   = mask_pos + 2'd1;
        if (last) parse_ph = PH_HDR;
        if (frame_fin) queue_result(KIND_DATA, b ^ key_byte, last);
        else if (last) queue_result(KIND_DROP, 8'h00, 1'b1);
      end
      default: begin
        frame_fin    = b[7];
        frame_op     = b[3:0];
        frame_masked = 1'b0;
        hdr_left     = 3'd0;
        parse_ph     = PH_LEN;
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      parse_ph     = PH_HDR;
      frame_fin    = 1'b0;
      frame_op     = 4'd0;
      frame_masked = 1'b0;
      hdr_left     = 3'd0;
      bytes_left   = 64'd0;
      mask_word    = 32'd0;
      mask_pos     = 2'd0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = res_t'({kind, data_byte, frame_opcode, frame_last, was_masked});
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: kind=%0d data=%02h op=%0h last=%0b masked=%0b",
                   $time, got.kind, got.data_byte, got.frame_opcode, got.frame_last,
                   got.was_masked);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch: expected kind=%0d data=%02h op=%0h last=%0b masked=%0b",
                     $time, want.kind, want.data_byte, want.frame_opcode, want.frame_last,
                     want.was_masked);
            $display("%0t:           actual kind=%0d data=%02h op=%0h last=%0b masked=%0b",
                     $time, got.kind, got.data_byte, got.frame_opcode, got.frame_last,
                     got.was_masked);
          end
        end
      end
      if (in_valid && in_ready) parse_byte(rx_byte);
    end
    pending_count  <= expected_results.size();
    mismatch_count <= mismatches;
    checked_count  <= checked;
  end

endmodule

// ----- tb/websocket_frame_deframer_core_tb.sv -----
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, byte-stream stimulus and the final verdict.
module websocket_frame_deframer_core_tb;
  import wsd_pkg::*;

  // Random byte budget, split evenly over the four idle/stall phases.
  localparam int RANDOM_BYTES = 1550;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  // Length encodings of a frame header.
  typedef enum int {
    FORM_SHORT,
    FORM_EXT16,
    FORM_EXT64
  } len_form_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [3:0] frame_opcode;
  logic       frame_last;
  logic       was_masked;

  int mismatch_count;
  int pending_count;
  int checked_count;

  // Sender idle and receiver stall rates, in percent.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // Long receiver hold-off: bump hold_seq to request one; counted down by the receiver.
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int bytes_sent  = 0;
  int frames_sent = 0;

  websocket_frame_deframer_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .frame_opcode (frame_opcode),
    .frame_last   (frame_last),
    .was_masked   (was_masked)
  );

  websocket_frame_deframer_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .frame_opcode   (frame_opcode),
    .frame_last     (frame_last),
    .was_masked     (was_masked),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: stall at random, or hold ready low for a full hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one byte, idling first at random; return at the edge that completes the transaction.
  // Keep in_valid high on return so back-to-back bytes stream without a bubble.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Drop valid and hold until the checker has no result outstanding.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Build one frame: header, length in the chosen form, optional key, then random payload.
  // payload_count may fall short of len to leave a huge frame open at the end of the run.
  task automatic send_frame(input logic fin, input logic [3:0] opc, input logic [2:0] rsv,
                            input logic masked, input len_form_t form, input logic [63:0] len,
                            input logic [31:0] key, input int payload_count);
    send_byte({fin, rsv, opc});
    case (form)
      FORM_EXT16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_EXT64: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
      default: send_byte({masked, len[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    end
    for (int i = 0; i < payload_count; i++) send_byte(8'($urandom_range(255)));
    frames_sent++;
  endtask

  // Mostly short final frames; some non-final, extended and non-minimal length encodings.
  task automatic random_frame();
    logic        fin;
    logic        masked;
    logic [63:0] len;
    len_form_t   form;
    int          pick;
    fin    = ($urandom_range(99) < 80);
    masked = 1'($urandom_range(1));
    pick   = $urandom_range(99);
    if (pick < 3) begin
      form = FORM_SHORT;
      len  = 64'd125;
    end else if (pick < 70) begin
      form = FORM_SHORT;
      len  = 64'($urandom_range(20));
    end else if (pick < 85) begin
      form = FORM_EXT16;
      len  = 64'($urandom_range(40));
    end else if (pick < 90) begin
      form = FORM_EXT16;
      len  = 64'($urandom_range(300, 126));
    end else begin
      form = FORM_EXT64;
      len  = 64'($urandom_range(30));
    end
    send_frame(fin, 4'($urandom_range(15)), 3'($urandom_range(7)), masked, form, len,
               $urandom, int'(len));
  endtask

  initial begin
    int phase_end;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty final frame, unmasked.
    send_byte(8'h81);
    send_byte(8'h00);
    // Non-final, opcode 15, masked, zero length: dropped on the last key byte.
    send_byte(8'h0F);
    send_byte(8'h80);
    send_byte(8'hDE);
    send_byte(8'hAD);
    send_byte(8'hBE);
    send_byte(8'hEF);
    // Final, all reserved bits set, opcode 0, all-ones key, payload at both byte extremes.
    send_byte(8'hF0);
    send_byte(8'h82);
    repeat (4) send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    // Non-final with one payload byte: dropped on that byte.
    send_byte(8'h02);
    send_byte(8'h01);
    send_byte(8'hAA);
    // 16-bit length form carrying a length that fits in seven bits.
    send_byte(8'h89);
    send_byte({1'b0, LEN_EXT16});
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h5A);
    frames_sent += 5;
    wait_drained();

    // Random phases: free flow (with one long hold-off), idle sender, stalling receiver, both.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          hold_seq <= hold_seq + 1;
        end
        1: begin
          tx_idle_pct = 68;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 68;
        end
        default: begin
          tx_idle_pct = 19;
          rx_stall_pct <= 19;
        end
      endcase
      phase_end = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < phase_end) random_frame();
      wait_drained();
    end

    // Leave a frame open whose 64-bit length has its top bit set: no byte may be last.
    tx_idle_pct = 19;
    send_frame(1'b1, 4'($urandom_range(15)), 3'd0, 1'b1, FORM_EXT64,
               64'h8000_0000_0000_0005, $urandom, 12);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d frames in %0d bytes, %0d results checked, over four idle/stall phases",
             frames_sent, bytes_sent, checked_count);
    $display("including a %0d-cycle output hold-off and an open frame with a huge length",
             HOLD_CYCLES);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("websocket_frame_deframer_core_tb OK");
    end else begin
      $display("websocket_frame_deframer_core_tb NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Timeout: run did not complete");
    $display("websocket_frame_deframer_core_tb NOT OK");
    $finish;
  end

endmodule

// ----- websocket_frame_deframer_core.f -----
+incdir+design
design/wsd_pkg.sv
design/wsd_in_reg.sv
design/wsd_parser.sv
design/wsd_out_reg.sv
design/websocket_frame_deframer_core.sv
tb/websocket_frame_deframer_checker.sv
tb/websocket_frame_deframer_core_tb.sv
